// File: hw/rtl/gvu_pkg.sv
// Shared types, constants and rounding helper for the gravity velocity update
package gvu_pkg;

  localparam int MAG_W     = 32;
  localparam int SQ_W      = 66;
  localparam int ROOT_W    = 34;
  localparam int Q_W       = 32;
  localparam int UNIT_FRAC = 30;
  localparam int ACC_SHIFT = 24;
  localparam int TOP_W     = 64 + ACC_SHIFT;
  localparam int RND_W     = 35;

  typedef struct packed {
    logic [31:0] own_x;
    logic [31:0] own_y;
    logic [31:0] own_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [30:0] own_radius;
    logic [31:0] other_x;
    logic [31:0] other_y;
    logic [31:0] other_z;
    logic [30:0] other_radius;
    logic [31:0] other_mass;
  } item_t;

  typedef struct packed {
    logic [31:0] new_vel_x;
    logic [31:0] new_vel_y;
    logic [31:0] new_vel_z;
    logic        collided;
    logic        saturated;
  } result_t;

  typedef struct packed {
    logic collided;
    logic nonzero;
    logic cap;
  } flags_t;

  // x / 2^30 to nearest, ties away from zero
  function automatic logic signed [RND_W-1:0] round30(input logic signed [63:0] x);
    logic signed [64:0] t;
    t = 65'(x) + (x[63] ? 65'sd536870911 : 65'sd536870912);
    return t[64:UNIT_FRAC];
  endfunction

endpackage

// File: hw/rtl/gvu_ifs.sv
// Valid/ready channel interfaces for items and results
interface gvu_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] own_x;
  logic [31:0] own_y;
  logic [31:0] own_z;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_z;
  logic [30:0] own_radius;
  logic [31:0] other_x;
  logic [31:0] other_y;
  logic [31:0] other_z;
  logic [30:0] other_radius;
  logic [31:0] other_mass;

  modport source(output valid, own_x, own_y, own_z, vel_x, vel_y, vel_z, own_radius,
                 other_x, other_y, other_z, other_radius, other_mass, input ready);
  modport sink(input valid, own_x, own_y, own_z, vel_x, vel_y, vel_z, own_radius,
               other_x, other_y, other_z, other_radius, other_mass, output ready);
endinterface

interface gvu_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_vel_x;
  logic [31:0] new_vel_y;
  logic [31:0] new_vel_z;
  logic        collided;
  logic        saturated;

  modport source(output valid, new_vel_x, new_vel_y, new_vel_z, collided, saturated,
                 input ready);
  modport sink(input valid, new_vel_x, new_vel_y, new_vel_z, collided, saturated,
               output ready);
endinterface

// File: hw/rtl/gvu_front.sv
// Front stages: separation, squared lengths, normalization, overlap and force terms
module gvu_front import gvu_pkg::*; #(
  parameter int DISTANCE_SCALE = 1000,
  localparam longint S2 = longint'(DISTANCE_SCALE) * longint'(DISTANCE_SCALE),
  localparam int S2_W = $clog2(S2 + 1),
  localparam int DEN_W = SQ_W + S2_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  item_t                  item,
  input  logic [31:0]            gravity,
  output logic                   out_valid,
  output logic [2:0][31:0]       vel,
  output logic [2:0]             neg,
  output logic [2:0][31:0]       an,
  output logic [SQ_W-1:0]        n2,
  output logic [TOP_W-1:0]       top,
  output logic [DEN_W-1:0]       den,
  output flags_t                 flags
);

  localparam int CMP_W = DEN_W > (TOP_W - 32) ? DEN_W : (TOP_W - 32);
  localparam logic [S2_W-1:0] S2C = S2_W'(S2);

  logic [6:0] vld;

  logic [2:0][32:0] d1;
  logic [2:0][31:0] vel1, vel2, vel3, vel4, vel5, vel6;
  logic [31:0]      rs1;
  logic [63:0]      num1;

  logic [2:0][31:0] a2, a3, a4;
  logic [2:0]       neg2, neg3, neg4, neg5, neg6;
  logic [63:0]      rs2_2, rs2_3, rs2_4;
  logic [TOP_W-1:0] top2, top3, top4, top5, top6;

  logic [2:0][63:0] sq3, sq6;
  logic [31:0]      m3;

  logic [SQ_W-1:0]  d2_4;
  logic [4:0]       sh4;
  logic             nz4, nz5, nz6;

  logic             coll5, coll6;
  logic [2:0][31:0] an5, an6;
  logic [32+S2_W-1:0] den_lo5;
  logic [34+S2_W-1:0] den_hi5;
  logic [DEN_W-1:0] den6;

  logic [4:0] lz;

  always_comb begin
    lz = '0;
    for (int i = 0; i < 32; i++) begin
      if (m3[i]) lz = 5'(31 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // separation
      d1[0] <= {item.other_x[31], item.other_x} - {item.own_x[31], item.own_x};
      d1[1] <= {item.other_y[31], item.other_y} - {item.own_y[31], item.own_y};
      d1[2] <= {item.other_z[31], item.other_z} - {item.own_z[31], item.own_z};
      vel1  <= {item.vel_z, item.vel_y, item.vel_x};
      rs1   <= 32'(item.own_radius) + 32'(item.other_radius);
      num1  <= 64'(gravity) * 64'(item.other_mass);

      // magnitudes
      for (int i = 0; i < 3; i++) begin
        neg2[i] <= d1[i][32];
        a2[i]   <= d1[i][32] ? 32'(33'd0 - d1[i]) : d1[i][31:0];
      end
      rs2_2 <= 64'(rs1) * 64'(rs1);
      top2  <= {num1, ACC_SHIFT'(0)};
      vel2  <= vel1;

      // squares, largest magnitude
      for (int i = 0; i < 3; i++) sq3[i] <= 64'(a2[i]) * 64'(a2[i]);
      m3 <= (a2[0] > a2[1]) ? ((a2[0] > a2[2]) ? a2[0] : a2[2])
                            : ((a2[1] > a2[2]) ? a2[1] : a2[2]);
      a3 <= a2; neg3 <= neg2; rs2_3 <= rs2_2; top3 <= top2; vel3 <= vel2;

      // squared length, normalizing shift
      d2_4 <= SQ_W'(sq3[0]) + SQ_W'(sq3[1]) + SQ_W'(sq3[2]);
      sh4  <= lz;
      nz4  <= m3 != 32'd0;
      a4 <= a3; neg4 <= neg3; rs2_4 <= rs2_3; top4 <= top3; vel4 <= vel3;

      // overlap test, normalized components, scaled denominator parts
      coll5 <= SQ_W'(rs2_4) > d2_4;
      for (int i = 0; i < 3; i++) an5[i] <= a4[i] << sh4;
      den_lo5 <= d2_4[31:0] * S2C;
      den_hi5 <= d2_4[SQ_W-1:32] * S2C;
      nz5 <= nz4; neg5 <= neg4; top5 <= top4; vel5 <= vel4;

      for (int i = 0; i < 3; i++) sq6[i] <= 64'(an5[i]) * 64'(an5[i]);
      den6 <= DEN_W'(den_lo5) + (DEN_W'(den_hi5) << 32);
      an6 <= an5; coll6 <= coll5; nz6 <= nz5; neg6 <= neg5; top6 <= top5; vel6 <= vel5;

      n2  <= SQ_W'(sq6[0]) + SQ_W'(sq6[1]) + SQ_W'(sq6[2]);
      flags.cap      <= CMP_W'(top6[TOP_W-1:32]) >= CMP_W'(den6);
      flags.collided <= coll6;
      flags.nonzero  <= nz6;
      an  <= an6; den <= den6; top <= top6; neg <= neg6; vel <= vel6;
    end
  end

  assign out_valid = vld[6];

endmodule

// File: hw/rtl/gvu_isqrt.sv
// Pipelined integer square root, one result bit per stage
module gvu_isqrt #(
  parameter int X_W  = 66,
  parameter int R_W  = 34,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [X_W-1:0]  x,
  input  logic [SB_W-1:0] sb_in,
  output logic            out_valid,
  output logic [R_W-1:0]  root,
  output logic [SB_W-1:0] sb_out
);

  localparam int TW = 2 * R_W + 1;

  logic            vv [R_W];
  logic [X_W-1:0]  rem [R_W];
  logic [R_W-1:0]  rt [R_W];
  logic [SB_W-1:0] ss [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_step
    localparam int B = R_W - 1 - k;
    logic            p_v;
    logic [X_W-1:0]  p_rem;
    logic [R_W-1:0]  p_rt;
    logic [SB_W-1:0] p_sb;
    logic [TW-1:0]   trial;
    logic            take;

    if (k == 0) begin : g_first
      assign p_v = in_valid;
      assign p_rem = x;
      assign p_rt = '0;
      assign p_sb = sb_in;
    end else begin : g_next
      assign p_v = vv[k-1];
      assign p_rem = rem[k-1];
      assign p_rt = rt[k-1];
      assign p_sb = ss[k-1];
    end

    assign trial = (TW'(p_rt) << (B + 1)) | (TW'(1) << (2 * B));
    assign take  = TW'(p_rem) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k] <= 1'b0;
      end else if (en) begin
        vv[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? X_W'(TW'(p_rem) - trial) : p_rem;
        rt[k]  <= take ? (p_rt | (R_W'(1) << B)) : p_rt;
        ss[k]  <= p_sb;
      end
    end
  end

  assign out_valid = vv[R_W-1];
  assign root      = rt[R_W-1];
  assign sb_out    = ss[R_W-1];

endmodule

// File: hw/rtl/gvu_div.sv
// Pipelined restoring divider, one quotient bit per stage
module gvu_div #(
  parameter int N_W  = 62,
  parameter int D_W  = 34,
  parameter int Q_W  = 32,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [N_W-1:0]  n,
  input  logic [D_W-1:0]  d,
  input  logic [SB_W-1:0] sb_in,
  output logic            out_valid,
  output logic [Q_W-1:0]  q,
  output logic [SB_W-1:0] sb_out
);

  logic            vv [Q_W];
  logic [D_W-1:0]  rr [Q_W];
  logic [D_W-1:0]  dd [Q_W];
  logic [Q_W-1:0]  qq [Q_W];
  logic [Q_W-1:0]  ll [Q_W];
  logic [SB_W-1:0] ss [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int B = Q_W - 1 - k;
    logic            p_v;
    logic [D_W-1:0]  p_r;
    logic [D_W-1:0]  p_d;
    logic [Q_W-1:0]  p_q;
    logic [Q_W-1:0]  p_l;
    logic [SB_W-1:0] p_sb;
    logic [D_W:0]    t;
    logic [D_W:0]    diff;
    logic            take;

    if (k == 0) begin : g_first
      assign p_v = in_valid;
      assign p_r = D_W'(n[N_W-1:Q_W]);
      assign p_d = d;
      assign p_q = '0;
      assign p_l = n[Q_W-1:0];
      assign p_sb = sb_in;
    end else begin : g_next
      assign p_v = vv[k-1];
      assign p_r = rr[k-1];
      assign p_d = dd[k-1];
      assign p_q = qq[k-1];
      assign p_l = ll[k-1];
      assign p_sb = ss[k-1];
    end

    assign t    = {p_r, p_l[B]};
    assign diff = t - {1'b0, p_d};
    assign take = t >= {1'b0, p_d};

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k] <= 1'b0;
      end else if (en) begin
        vv[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr[k] <= take ? diff[D_W-1:0] : t[D_W-1:0];
        qq[k] <= take ? (p_q | (Q_W'(1) << B)) : p_q;
        dd[k] <= p_d;
        ll[k] <= p_l;
        ss[k] <= p_sb;
      end
    end
  end

  assign out_valid = vv[Q_W-1];
  assign q         = qq[Q_W-1];
  assign sb_out    = ss[Q_W-1];

endmodule

// File: hw/rtl/gvu_back.sv
// Back stages: unit vector, reflection, acceleration and saturation
module gvu_back import gvu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2:0][31:0] uq,
  input  logic [2:0]       neg,
  input  logic [31:0]      accq,
  input  flags_t           flags,
  input  logic [2:0][31:0] vel,
  output logic             out_valid,
  output result_t          result
);

  logic [6:0] vld;

  logic [2:0][31:0] u1, u2, u3, u4;
  logic [32:0]      acc1;
  logic [2:0][31:0] vel1, vel2, vel3, vel4, vel5;
  logic             coll1, coll2, coll3, coll4, coll5, coll6;

  logic [2:0][63:0] dp2, ap2;
  logic [63:0]      dot3;
  logic [2:0][RND_W-1:0] ga3, ga4, ga5, ga6;
  logic [RND_W-1:0] pd4;
  logic [2:0][63:0] pu5;
  logic [2:0][RND_W-1:0] vr6;

  logic [2:0][RND_W:0]   sum;
  logic [2:0][31:0]      clip;
  logic [2:0]            ovf;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = {vr6[i][RND_W-1], vr6[i]} + {ga6[i][RND_W-1], ga6[i]};
      ovf[i] = sum[i][RND_W:31] != {(RND_W-30){sum[i][31]}};
      if (!ovf[i]) begin
        clip[i] = sum[i][31:0];
      end else if (sum[i][RND_W]) begin
        clip[i] = 32'h8000_0000;
      end else begin
        clip[i] = 32'h7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u1[i] <= !flags.nonzero ? 32'd0 : (neg[i] ? 32'd0 - uq[i] : uq[i]);
      end
      acc1  <= !flags.nonzero ? 33'd0 : (flags.cap ? 33'h1_0000_0000 : {1'b0, accq});
      coll1 <= flags.collided;
      vel1  <= vel;

      for (int i = 0; i < 3; i++) begin
        dp2[i] <= $signed(u1[i]) * $signed(vel1[i]);
        ap2[i] <= $signed({1'b0, acc1}) * $signed(u1[i]);
      end
      u2 <= u1; vel2 <= vel1; coll2 <= coll1;

      dot3 <= dp2[0] + dp2[1] + dp2[2];
      for (int i = 0; i < 3; i++) ga3[i] <= round30(ap2[i]);
      u3 <= u2; vel3 <= vel2; coll3 <= coll2;

      pd4 <= round30(dot3);
      ga4 <= ga3; u4 <= u3; vel4 <= vel3; coll4 <= coll3;

      for (int i = 0; i < 3; i++) pu5[i] <= $signed(pd4) * $signed(u4[i]);
      ga5 <= ga4; vel5 <= vel4; coll5 <= coll4;

      for (int i = 0; i < 3; i++) begin
        vr6[i] <= coll5 ? RND_W'(-round30(pu5[i])) : RND_W'($signed(vel5[i]));
      end
      ga6 <= ga5; coll6 <= coll5;

      result.new_vel_x <= clip[0];
      result.new_vel_y <= clip[1];
      result.new_vel_z <= clip[2];
      result.collided  <= coll6;
      result.saturated <= |ovf;
    end
  end

  assign out_valid = vld[6];

endmodule

// File: hw/rtl/pairwise_gravity_velocity_update.sv
// Top level: pairwise gravity velocity update pipeline with output skid buffer
// Stages: 7 front, 34 square root, 32 divide, 7 back, 1 output register.
// Throughput: one item per cycle; the whole pipeline holds only once the skid
// register behind a stalled output is full.
// Reset: rst clears all valid bits and sets gravity to zero.
module pairwise_gravity_velocity_update import gvu_pkg::*; #(
  parameter int DISTANCE_SCALE = 1000
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          gravity_we,
  input  logic [31:0]   gravity_wdata,
  gvu_item_if.sink      items,
  gvu_result_if.source  results
);

  localparam longint S2 = longint'(DISTANCE_SCALE) * longint'(DISTANCE_SCALE);
  localparam int S2_W  = $clog2(S2 + 1);
  localparam int DEN_W = SQ_W + S2_W;
  localparam int SQ_SB_W = 3 * 32 * 2 + 3 + TOP_W + DEN_W + $bits(flags_t);
  localparam int AC_SB_W = 3 * 32 + $bits(flags_t);

  logic [31:0] gravity;
  logic        en;

  item_t item;

  logic             f_valid;
  logic [2:0][31:0] f_vel, f_an;
  logic [2:0]       f_neg;
  logic [SQ_W-1:0]  f_n2;
  logic [TOP_W-1:0] f_top;
  logic [DEN_W-1:0] f_den;
  flags_t           f_flags;

  logic               s_valid;
  logic [ROOT_W-1:0]  s_root;
  logic [SQ_SB_W-1:0] s_sb;
  logic [2:0][31:0]   s_vel, s_an;
  logic [2:0]         s_neg;
  logic [TOP_W-1:0]   s_top;
  logic [DEN_W-1:0]   s_den;
  flags_t             s_flags;

  logic [2:0][31:0]   q_u;
  logic [2:0]         q_neg;
  logic               q_valid;
  logic [31:0]        q_acc;
  logic [AC_SB_W-1:0] q_sb;
  logic [2:0][31:0]   q_vel;
  flags_t             q_flags;

  logic    b_valid;
  result_t b_result;

  logic    out_valid, skid_valid;
  result_t out_data, skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= '0;
    end else if (gravity_we) begin
      gravity <= gravity_wdata;
    end
  end

  assign en = !skid_valid;
  assign items.ready = en;

  assign item = '{own_x: items.own_x, own_y: items.own_y, own_z: items.own_z,
                  vel_x: items.vel_x, vel_y: items.vel_y, vel_z: items.vel_z,
                  own_radius: items.own_radius, other_x: items.other_x,
                  other_y: items.other_y, other_z: items.other_z,
                  other_radius: items.other_radius, other_mass: items.other_mass};

  gvu_front #(.DISTANCE_SCALE(DISTANCE_SCALE)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(items.valid), .item(item),
    .gravity(gravity), .out_valid(f_valid), .vel(f_vel), .neg(f_neg), .an(f_an),
    .n2(f_n2), .top(f_top), .den(f_den), .flags(f_flags)
  );

  gvu_isqrt #(.X_W(SQ_W), .R_W(ROOT_W), .SB_W(SQ_SB_W)) u_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid), .x(f_n2),
    .sb_in({f_vel, f_neg, f_an, f_top, f_den, f_flags}),
    .out_valid(s_valid), .root(s_root), .sb_out(s_sb)
  );

  assign {s_vel, s_neg, s_an, s_top, s_den, s_flags} = s_sb;

  for (genvar i = 0; i < 3; i++) begin : g_unit
    gvu_div #(.N_W(MAG_W + UNIT_FRAC), .D_W(ROOT_W), .Q_W(Q_W), .SB_W(1)) u_div (
      .clk(clk), .rst(rst), .en(en), .in_valid(s_valid),
      .n({s_an[i], UNIT_FRAC'(0)}), .d(s_root), .sb_in(s_neg[i]),
      .out_valid(), .q(q_u[i]), .sb_out(q_neg[i])
    );
  end

  gvu_div #(.N_W(TOP_W), .D_W(DEN_W), .Q_W(Q_W), .SB_W(AC_SB_W)) u_acc_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid), .n(s_top), .d(s_den),
    .sb_in({s_vel, s_flags}), .out_valid(q_valid), .q(q_acc), .sb_out(q_sb)
  );

  assign {q_vel, q_flags} = q_sb;

  gvu_back u_back (
    .clk(clk), .rst(rst), .en(en), .in_valid(q_valid), .uq(q_u), .neg(q_neg),
    .accq(q_acc), .flags(q_flags), .vel(q_vel), .out_valid(b_valid), .result(b_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (results.ready || !out_valid) begin
      out_valid  <= skid_valid || (en && b_valid);
      skid_valid <= 1'b0;
    end else if (en && b_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (results.ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : b_result;
    end else if (en && b_valid) begin
      skid_data <= b_result;
    end
  end

  assign results.valid     = out_valid;
  assign results.new_vel_x = out_data.new_vel_x;
  assign results.new_vel_y = out_data.new_vel_y;
  assign results.new_vel_z = out_data.new_vel_z;
  assign results.collided  = out_data.collided;
  assign results.saturated = out_data.saturated;

  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !results.ready |=> skid_valid)
    else $error("skid result dropped during output stall");

  a_skid_load: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(results.valid && !results.ready))
    else $error("skid loaded without output stall");

endmodule
